[hdl/accel_tilt_normalize_smooth_unit_defines.svh]
// assertion macros for the tilt normalize and smooth unit
`ifndef ACCEL_TILT_NORMALIZE_SMOOTH_UNIT_DEFINES_SVH
`define ACCEL_TILT_NORMALIZE_SMOOTH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ATNS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ATNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/atns_pkg.sv]
// shared types and constants of the tilt normalize and smooth unit
`default_nettype none

package atns_pkg;

  localparam int AXIS_W = 16;
  localparam int COEFF_W = 17;
  localparam int AMP_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_AMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd2;

  localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 17'd26214;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd2048;

  localparam int MAG_W = 32;
  localparam int SQ_W = 31;
  localparam int QUO_W = 32;
  localparam int ROOT_W = 16;
  localparam int SQRT_REM_W = 19;
  localparam int NCNT_W = 5;
  localparam logic [NCNT_W-1:0] DIV_LAST = 5'd30;
  localparam logic [NCNT_W-1:0] SQRT_LAST = 5'd15;
  localparam logic signed [ROOT_W-1:0] TARGET_MAX = 16'sd32767;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_TICK,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [AXIS_W-1:0]  accel_x;
    logic signed [AXIS_W-1:0]  accel_y;
    logic signed [AXIS_W-1:0]  accel_z;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [SQ_W-1:0]  sq;
    logic [MAG_W-1:0] mag;
    logic             neg;
  } norm_req_t;

  typedef enum logic [1:0] {
    NORM_IDLE,
    NORM_DIV,
    NORM_SQRT
  } norm_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_SMOOTH,
    ST_ANGLE,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

[hdl/atns_front.sv]
// input side: takes requests and sorts them into sample, tick or rejected sample
`default_nettype none

module atns_front (
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [3*atns_pkg::AXIS_W-1:0] data_i,
  input  wire logic                        user_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output atns_pkg::cmd_t                   cmd_o
);
  import atns_pkg::*;

  logic all_zero;

  assign all_zero = ~|data_i;
  assign ready_o  = !q_full_i;
  assign push_o   = valid_i && !q_full_i;

  always_comb begin
    cmd_o.accel_x = data_i[AXIS_W-1:0];
    cmd_o.accel_y = data_i[2*AXIS_W-1:AXIS_W];
    cmd_o.accel_z = data_i[3*AXIS_W-1:2*AXIS_W];
    if (user_i) begin
      cmd_o.kind = CMD_TICK;
    end else if (all_zero) begin
      cmd_o.kind = CMD_REJECT;
    end else begin
      cmd_o.kind = CMD_SAMPLE;
    end
  end

endmodule

`default_nettype wire

[hdl/atns_fifo.sv]
// two-entry request queue between the input side and the execution side
`default_nettype none

module atns_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire atns_pkg::cmd_t cmd_i,
  output logic            full_o,
  output logic            valid_o,
  output atns_pkg::cmd_t  head_o,
  input  wire logic       pop_i
);
  import atns_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hdl/atns_norm.sv]
// one axis of normalization: bit-serial divide then digit-by-digit square root
`default_nettype none

module atns_norm (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire atns_pkg::norm_req_t           req_i,
  output logic                               done_o,
  output logic signed [atns_pkg::ROOT_W-1:0] res_o
);
  import atns_pkg::*;

  norm_state_e         state_q, state_d;
  logic [NCNT_W-1:0]   cnt_q;
  logic [MAG_W:0]      rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [ROOT_W-1:0]   root_q;
  logic [MAG_W-1:0]    mag_q;
  logic                lsb_q;
  logic                neg_q;

  logic                div_en, sqrt_en, last;
  logic                in_bit;
  logic [MAG_W:0]      div_rem;
  logic                div_ge;
  logic [SQRT_REM_W-1:0] sq_rem, sq_trial;
  logic                sq_ge;
  logic [ROOT_W:0]     neg_root;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NORM_IDLE: begin
        if (req_i.start) state_d = NORM_DIV;
      end
      NORM_DIV: begin
        if (cnt_q == DIV_LAST) state_d = NORM_SQRT;
      end
      NORM_SQRT: begin
        if (cnt_q == SQRT_LAST) state_d = NORM_IDLE;
      end
      default: state_d = NORM_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    div_en  = 1'b0;
    sqrt_en = 1'b0;
    last    = 1'b0;
    unique case (state_q)
      NORM_IDLE: ;
      NORM_DIV: begin
        div_en = 1'b1;
        last   = (cnt_q == DIV_LAST);
      end
      NORM_SQRT: begin
        sqrt_en = 1'b1;
        last    = (cnt_q == SQRT_LAST);
      end
      default: ;
    endcase
  end

  // restoring divide step of (sq << 30) by the squared magnitude
  assign in_bit  = (cnt_q == '0) ? lsb_q : 1'b0;
  assign div_rem = {rem_q[MAG_W-1:0], in_bit};
  assign div_ge  = (div_rem >= {1'b0, mag_q});

  // square root step over the quotient, two bits at a time
  assign sq_rem   = {rem_q[SQRT_REM_W-3:0], quo_q[QUO_W-1:QUO_W-2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);

  assign done_o   = (state_q == NORM_IDLE);
  assign neg_root = -{1'b0, root_q};

  always_comb begin
    if (neg_q) begin
      res_o = neg_root[ROOT_W-1:0];
    end else if (root_q[ROOT_W-1]) begin
      res_o = TARGET_MAX;
    end else begin
      res_o = root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NORM_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (req_i.start && done_o) begin
        cnt_q <= '0;
      end else if (div_en || sqrt_en) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && done_o) begin
      rem_q  <= {3'b000, req_i.sq[SQ_W-1:1]};
      lsb_q  <= req_i.sq[0];
      mag_q  <= req_i.mag;
      neg_q  <= req_i.neg;
      quo_q  <= '0;
      root_q <= '0;
    end else if (div_en) begin
      if (last) begin
        rem_q <= '0;
      end else begin
        rem_q <= div_ge ? div_rem - {1'b0, mag_q} : div_rem;
      end
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
    end else if (sqrt_en) begin
      rem_q  <= {{(MAG_W+1-SQRT_REM_W){1'b0}}, sq_ge ? sq_rem - sq_trial : sq_rem};
      quo_q  <= {quo_q[QUO_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end
  end

endmodule

`default_nettype wire

[hdl/atns_back.sv]
// execution side: squares, normalize handoff, smoothing, angle scaling, result register
`default_nettype none

module atns_back #(
  parameter int SMOOTH_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  input  wire atns_pkg::cmd_t                  cmd_i,
  output logic                                 cmd_pop_o,
  input  wire logic [atns_pkg::COEFF_W-1:0]    coeff_i,
  input  wire logic [atns_pkg::AMP_W-1:0]      amp_i,
  input  wire logic                            invert_i,
  output atns_pkg::norm_req_t                  req_lr_o,
  output atns_pkg::norm_req_t                  req_ud_o,
  input  wire logic                            lr_done_i,
  input  wire logic                            ud_done_i,
  input  wire logic signed [atns_pkg::ROOT_W-1:0] lr_res_i,
  input  wire logic signed [atns_pkg::ROOT_W-1:0] ud_res_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [atns_pkg::AXIS_W-1:0]   out_angle_x_o,
  output logic signed [atns_pkg::AXIS_W-1:0]   out_angle_y_o,
  output logic                                 out_rej_o
);
  import atns_pkg::*;

  localparam int SB = SMOOTH_BITS;
  localparam logic [SB+15:0] ROUND = (SB+16)'(1) << (SB-2);

  back_state_e               state_q, state_d;
  logic [1:0]                step_q;
  cmd_t                      cmd_q;
  logic                      rej_q;
  logic [SQ_W-1:0]           sq_lr_q, sq_ud_q;
  logic [MAG_W-1:0]          mag_q;
  logic signed [AXIS_W-1:0]  target_lr_q, target_ud_q;
  logic signed [SB-1:0]      smooth_lr_q, smooth_ud_q;
  logic signed [AXIS_W-1:0]  angle_x_q, angle_y_q;
  logic                      out_valid_q;
  logic signed [AXIS_W-1:0]  out_ax_q, out_ay_q;
  logic                      out_rej_q;

  logic                      out_free, norm_fin, lane;
  logic                      pop, sq_en, go, smooth_en, angle_en, load_out;
  logic signed [AXIS_W-1:0]  sq_sel;
  logic signed [2*AXIS_W-1:0] sq_full;
  logic signed [AXIS_W-1:0]  t_sel;
  logic signed [SB-1:0]      s_sel, t_ext, tw, s_new;
  logic signed [SB:0]        diff;
  logic [COEFF_W-1:0]        c_sat;
  logic signed [SB+18:0]     sprod, sstep;
  logic signed [SB+15:0]     aprod, arnd, ashift;
  logic signed [AXIS_W:0]    a_pos, a_fin;

  assign out_free = !out_valid_q || out_ready_i;
  assign norm_fin = lr_done_i && ud_done_i;
  assign lane     = step_q[0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_SAMPLE: state_d = ST_SQUARE;
            CMD_TICK:   state_d = ST_SMOOTH;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_SQUARE:    if (step_q == 2'd2) state_d = ST_NORM_GO;
      ST_NORM_GO:   state_d = ST_NORM_WAIT;
      ST_NORM_WAIT: if (norm_fin) state_d = ST_OUT;
      ST_SMOOTH:    if (lane) state_d = ST_ANGLE;
      ST_ANGLE:     if (lane) state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    pop       = 1'b0;
    sq_en     = 1'b0;
    go        = 1'b0;
    smooth_en = 1'b0;
    angle_en  = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE:      pop = cmd_valid_i;
      ST_SQUARE:    sq_en = 1'b1;
      ST_NORM_GO:   go = 1'b1;
      ST_NORM_WAIT: ;
      ST_SMOOTH:    smooth_en = 1'b1;
      ST_ANGLE:     angle_en = 1'b1;
      ST_OUT:       load_out = out_free;
      default: ;
    endcase
  end

  assign cmd_pop_o = pop;

  // one shared squarer, axes in turn
  always_comb begin
    case (step_q)
      2'd0:    sq_sel = cmd_q.accel_y;
      2'd1:    sq_sel = cmd_q.accel_x;
      default: sq_sel = cmd_q.accel_z;
    endcase
  end
  assign sq_full = sq_sel * sq_sel;

  always_comb begin
    req_lr_o.start = go;
    req_lr_o.sq    = sq_lr_q;
    req_lr_o.mag   = mag_q;
    req_lr_o.neg   = cmd_q.accel_y[AXIS_W-1];
    req_ud_o.start = go;
    req_ud_o.sq    = sq_ud_q;
    req_ud_o.mag   = mag_q;
    req_ud_o.neg   = cmd_q.accel_x[AXIS_W-1];
  end

  // low-pass step, one lane per cycle
  assign s_sel = lane ? smooth_ud_q : smooth_lr_q;
  assign t_sel = lane ? target_ud_q : target_lr_q;
  assign t_ext = SB'(t_sel);
  assign tw    = t_ext <<< (SB - AXIS_W);
  assign diff  = (SB+1)'(tw) - (SB+1)'(s_sel);
  assign c_sat = (coeff_i > COEFF_ONE) ? COEFF_ONE : coeff_i;
  assign sprod = diff * $signed({1'b0, c_sat});
  assign sstep = sprod >>> 16;
  assign s_new = s_sel + SB'(sstep);

  // angle scaling with round half up
  assign aprod  = s_sel * $signed({1'b0, amp_i});
  assign arnd   = aprod + $signed(ROUND);
  assign ashift = arnd >>> (SB - 1);
  assign a_pos  = ashift[AXIS_W:0];
  assign a_fin  = invert_i ? -a_pos : a_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      target_lr_q <= '0;
      target_ud_q <= '0;
      smooth_lr_q <= '0;
      smooth_ud_q <= '0;
      angle_x_q   <= '0;
      angle_y_q   <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= (state_d != state_q) ? 2'd0 : step_q + 2'd1;
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
      if (state_q == ST_NORM_WAIT && norm_fin) begin
        target_lr_q <= lr_res_i;
        target_ud_q <= ud_res_i;
      end
      if (smooth_en) begin
        if (lane) smooth_ud_q <= s_new;
        else      smooth_lr_q <= s_new;
      end
      if (angle_en) begin
        if (lane) angle_x_q <= a_fin[AXIS_W-1:0];
        else      angle_y_q <= a_fin[AXIS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
      rej_q <= (cmd_i.kind == CMD_REJECT);
      mag_q <= '0;
    end else if (sq_en) begin
      mag_q <= mag_q + {1'b0, sq_full[SQ_W-1:0]};
      if (step_q == 2'd0) sq_lr_q <= sq_full[SQ_W-1:0];
      if (step_q == 2'd1) sq_ud_q <= sq_full[SQ_W-1:0];
    end
    if (load_out) begin
      out_ax_q  <= angle_x_q;
      out_ay_q  <= angle_y_q;
      out_rej_q <= rej_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_angle_x_o = out_ax_q;
  assign out_angle_y_o = out_ay_q;
  assign out_rej_o     = out_rej_q;

endmodule

`default_nettype wire

[hdl/accel_tilt_normalize_smooth_unit.sv]
// top level of the accelerometer tilt normalize and smooth unit
// sample: result after 3 squares, 31 divide steps and 16 root steps
// tick: result after smoothing and angle scaling of both lanes; rejected all-zero sample: straight to output
// one request at a time in the execution side: the next is taken once the last result is loaded
// two-entry queue keeps the input side taking requests while a result waits, until it is full
// async active-low reset: config to defaults, targets, smoothing and angles zero, queue empty
`default_nettype none
`include "accel_tilt_normalize_smooth_unit_defines.svh"

module accel_tilt_normalize_smooth_unit #(
  parameter int SMOOTH_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // accel_x, accel_y, accel_z
  input  wire logic [3*atns_pkg::AXIS_W-1:0]      s_axis_tdata,
  // mode
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // angle_about_x, angle_about_y
  output logic [2*atns_pkg::AXIS_W-1:0]           m_axis_tdata,
  // sample_rejected
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [atns_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [atns_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import atns_pkg::*;

  logic [COEFF_W-1:0]       coeff_q;
  logic [AMP_W-1:0]         amp_q;
  logic                     invert_q;

  logic                     q_push, q_full, q_valid, q_pop;
  cmd_t                     q_in, q_head;
  norm_req_t                norm_req_lr, norm_req_ud;
  logic                     lr_done, ud_done;
  logic signed [ROOT_W-1:0] lr_res, ud_res;
  logic signed [AXIS_W-1:0] out_ax, out_ay;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q  <= COEFF_RESET;
      amp_q    <= AMP_RESET;
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SMOOTH_COEFF: coeff_q  <= cfg_data_i[COEFF_W-1:0];
        CFG_TILT_AMP:     amp_q    <= cfg_data_i[AMP_W-1:0];
        CFG_INVERT:       invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  atns_front u_front (
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .data_i   (s_axis_tdata),
    .user_i   (s_axis_tuser),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in)
  );

  atns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  atns_norm u_norm_lr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req_lr),
    .done_o (lr_done),
    .res_o  (lr_res)
  );

  atns_norm u_norm_ud (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req_ud),
    .done_o (ud_done),
    .res_o  (ud_res)
  );

  atns_back #(
    .SMOOTH_BITS (SMOOTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .cmd_pop_o     (q_pop),
    .coeff_i       (coeff_q),
    .amp_i         (amp_q),
    .invert_i      (invert_q),
    .req_lr_o      (norm_req_lr),
    .req_ud_o      (norm_req_ud),
    .lr_done_i     (lr_done),
    .ud_done_i     (ud_done),
    .lr_res_i      (lr_res),
    .ud_res_i      (ud_res),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_angle_x_o (out_ax),
    .out_angle_y_o (out_ay),
    .out_rej_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {out_ay, out_ax};

  `ATNS_ASSERT_SAME(a_pop_has_head, q_pop, q_valid, "queue popped while empty")
  `ATNS_ASSERT_SAME(a_lanes_lockstep, 1'b1, lr_done == ud_done, "normalize lanes out of step")
  `ATNS_ASSERT_SAME(a_go_when_idle, norm_req_lr.start, lr_done && ud_done, "normalize started busy")
  `ATNS_ASSERT_NEXT(a_go_then_busy, norm_req_lr.start, !lr_done && !ud_done, "normalize did not start")

endmodule

`default_nettype wire
